/* hdl/energy_vad_segmenter_core_defines.svh */
// Assertion macros used by the checker file of the segmenter.
// Depends on nothing; include it before any module that asserts.
`ifndef ENERGY_VAD_SEGMENTER_CORE_DEFINES_SVH
`define ENERGY_VAD_SEGMENTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define EVS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define EVS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/evs_pkg.sv */
// Shared types and constants of the energy VAD segmenter.
// No dependencies; every module file refers to it by scoped names.
package evs_pkg;

  localparam int SUM_W = 31;
  localparam int PCNT_W = 16;
  localparam int SPK_W = 32;
  localparam int CH_W = 4;
  localparam int FR_W = 13;
  localparam int HANG_W = 16;
  localparam int MINFR_W = 19;
  localparam int LEVEL_W = 15;
  localparam int NOISE_W = 24;
  localparam int THR_W = 27;
  localparam int PROD_W = 43;
  localparam int DVD_W = 39;
  localparam int DVR_W = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 19;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [PCNT_W-1:0] PCNT_MAX = {PCNT_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CONSUMER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_INIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd4;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DELIVERED = 3'd1,
    EV_SHORT     = 3'd2,
    EV_QFULL     = 3'd3,
    EV_NOCONS    = 3'd4
  } evt_t;

  // One finished packet as handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [PCNT_W-1:0] cnt;
    logic [FR_W-1:0]   frames;
    logic [CH_W-1:0]   ch;
    logic [SPK_W-1:0]  spk;
    logic              qfull;
  } pkt_t;

  typedef struct packed {
    logic                consumer_present;
    logic [HANG_W-1:0]   hangover_ms;
    logic [MINFR_W-1:0]  min_utterance_frames;
    logic [LEVEL_W-1:0]  noise_floor_init;
    logic [LEVEL_W-1:0]  threshold_offset;
  } cfg_t;

endpackage

/* hdl/evs_front.sv */
// Front of the segmenter: accumulates sample magnitudes per packet and
// queues a record at each nonzero-frame packet end. Depends on evs_pkg.
module evs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [evs_pkg::SPK_W-1:0]   speaker_id,
  input  logic [evs_pkg::CH_W-1:0]    channel_count,
  input  logic [evs_pkg::FR_W-1:0]    packet_frames,
  input  logic signed [15:0]          sample,
  input  logic                        packet_end,
  input  logic                        queue_full,
  output logic                        q_push,
  output evs_pkg::pkt_t               q_rec,
  input  logic                        q_full
);

  logic [evs_pkg::SUM_W-1:0]  sum;
  logic [evs_pkg::PCNT_W-1:0] cnt;
  logic [15:0]                mag;
  logic [evs_pkg::SUM_W:0]    sum_wide;
  logic [evs_pkg::SUM_W-1:0]  sum_next;
  logic [evs_pkg::PCNT_W-1:0] cnt_next;
  logic                       accept;

  assign full = q_full;
  assign accept = push && !full;
  // The most negative sample wraps to 0x8000, which is its true magnitude.
  assign mag = sample[15] ? 16'(16'd0 - sample) : sample;
  assign sum_wide = {1'b0, sum} + (evs_pkg::SUM_W + 1)'(mag);
  assign sum_next = sum_wide[evs_pkg::SUM_W] ? evs_pkg::SUM_MAX
                                             : sum_wide[evs_pkg::SUM_W-1:0];
  assign cnt_next = (cnt == evs_pkg::PCNT_MAX) ? cnt : cnt + 1'b1;

  assign q_push = accept && packet_end && (packet_frames != '0);
  assign q_rec.sum = sum_next;
  assign q_rec.cnt = cnt_next;
  assign q_rec.frames = packet_frames;
  assign q_rec.ch = channel_count;
  assign q_rec.spk = speaker_id;
  assign q_rec.qfull = queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      cnt <= '0;
    end else if (accept) begin
      if (packet_end) begin
        sum <= '0;
        cnt <= '0;
      end else begin
        sum <= sum_next;
        cnt <= cnt_next;
      end
    end
  end

endmodule

/* hdl/evs_fifo.sv */
// Short queue of packet records between the front and the back.
// Depends on evs_pkg for the record type.
module evs_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  evs_pkg::pkt_t din,
  output logic          full,
  input  logic          pop,
  output evs_pkg::pkt_t dout,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  evs_pkg::pkt_t    mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [LVL_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign full = (level == LVL_W'(DEPTH));
  assign empty = (level == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      level <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

/* hdl/evs_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on evs_pkg for its widths.
module evs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [evs_pkg::DVD_W-1:0] dividend,
  input  logic [evs_pkg::DVR_W-1:0] divisor,
  output logic                      done,
  output logic [evs_pkg::DVD_W-1:0] quotient
);

  localparam int CW = $clog2(evs_pkg::DVD_W + 1);

  logic [evs_pkg::DVR_W-1:0] rem;
  logic [evs_pkg::DVR_W-1:0] dvr;
  logic [CW-1:0]             steps;
  logic                      busy;
  logic [evs_pkg::DVR_W:0]   trial;
  logic [evs_pkg::DVR_W:0]   diff;
  logic                      ge;

  assign trial = {rem, quotient[evs_pkg::DVD_W-1]};
  assign diff = trial - {1'b0, dvr};
  assign ge = (trial >= {1'b0, dvr});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem <= '0;
      dvr <= divisor;
    end else if (busy) begin
      quotient <= {quotient[evs_pkg::DVD_W-2:0], ge};
      rem <= ge ? diff[evs_pkg::DVR_W-1:0] : trial[evs_pkg::DVR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= CW'(evs_pkg::DVD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/evs_back.sv */
// Back of the segmenter: slot lookup, noise floor, voicing decision and
// utterance end, sequenced around the shared divider. Depends on evs_pkg,
// evs_div.
module evs_back #(
  parameter int SPEAKER_SLOTS = 8,
  parameter int MAX_SECONDS = 10,
  parameter int SAMPLE_RATE = 48000,
  parameter int MAX_PACKET_FRAMES = 4096,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  evs_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  input  evs_pkg::pkt_t                 q_rec,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [2:0]                    slot_index,
  output logic                          voiced,
  output logic                          append_packet,
  output logic [2:0]                    utterance_event,
  output logic [18:0]                   utterance_frames,
  output logic [evs_pkg::SPK_W-1:0]     utterance_speaker,
  output logic [evs_pkg::CH_W-1:0]      utterance_channels
);

  localparam int SLOT_W = (SPEAKER_SLOTS > 1) ? $clog2(SPEAKER_SLOTS) : 1;
  localparam int CAP1 = SAMPLE_RATE * MAX_SECONDS;
  localparam int CAPW = $clog2(CAP1 * MAX_CHANNELS + 1);
  localparam int AW = ((CAPW > evs_pkg::PCNT_W) ? CAPW : evs_pkg::PCNT_W) + 1;
  localparam int FRW = 17;

  // The packet duration divides by a constant rate. A reciprocal with enough
  // fraction bits, folded with the factor of 1000, gives the exact floor.
  localparam longint MS_X_MAX = longint'(MAX_PACKET_FRAMES) * 1000;
  localparam int MS_SHIFT = $clog2(MS_X_MAX * SAMPLE_RATE + 1);
  localparam longint MS_MUL =
    (((longint'(1) << MS_SHIFT) + SAMPLE_RATE - 1) / SAMPLE_RATE) * 1000;
  localparam int MSM_W = $clog2(MS_MUL + 1);
  localparam int MSP_W = FRW + MSM_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLAIM  = 9'b000000010,
    S_LVL    = 9'b000000100,
    S_THR    = 9'b000001000,
    S_PROD   = 9'b000010000,
    S_VOICE  = 9'b000100000,
    S_CAP    = 9'b001000000,
    S_UFR    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [evs_pkg::SPK_W-1:0]   slot_speaker  [SPEAKER_SLOTS];
  logic                        slot_active   [SPEAKER_SLOTS];
  logic [evs_pkg::CH_W-1:0]    slot_channels [SPEAKER_SLOTS];
  logic [CAPW-1:0]             slot_count    [SPEAKER_SLOTS];
  logic                        slot_speaking [SPEAKER_SLOTS];
  logic [evs_pkg::HANG_W-1:0]  slot_silence  [SPEAKER_SLOTS];
  logic [evs_pkg::NOISE_W-1:0] slot_noise    [SPEAKER_SLOTS];

  evs_pkg::pkt_t               rec;
  logic [SLOT_W-1:0]           s;
  logic [evs_pkg::THR_W-1:0]   thresh;
  logic [evs_pkg::PROD_W-1:0]  prod;
  logic [evs_pkg::HANG_W-1:0]  ms;
  logic                        voiced_r;
  logic                        append_r;
  logic [2:0]                  evt_r;
  logic [18:0]                 ufr_r;
  logic [evs_pkg::SPK_W-1:0]   uspk_r;
  logic [evs_pkg::CH_W-1:0]    uch_r;

  // Divider hookup.
  logic                        div_start;
  logic [evs_pkg::DVD_W-1:0]   div_dvd;
  logic [evs_pkg::DVR_W-1:0]   div_dvr;
  logic                        div_done;
  logic [evs_pkg::DVD_W-1:0]   div_quo;

  // Lookup.
  logic                        hit_found;
  logic [SLOT_W-1:0]           hit_idx;
  logic [SLOT_W-1:0]           claim_idx;
  logic [SLOT_W-1:0]           pick;
  logic [evs_pkg::CH_W-1:0]    ch_sat;
  logic [FRW-1:0]              fr_sat;
  logic [MSP_W-1:0]            ms_prod;
  logic [evs_pkg::HANG_W-1:0]  ms_calc;

  // Datapath of the selected slot.
  logic [evs_pkg::NOISE_W-1:0] cur_noise;
  logic                        cur_speak;
  logic [evs_pkg::HANG_W-1:0]  cur_sil;
  logic [CAPW-1:0]             cur_count;
  logic [evs_pkg::CH_W-1:0]    cur_ch;
  logic [31:0]                 mul_a;
  logic [31:0]                 mul_b;
  logic [31:0]                 mix;
  logic [evs_pkg::THR_W-1:0]   thresh_next;
  logic [evs_pkg::PROD_W-1:0]  level_big;
  logic                        voiced_c;
  logic [evs_pkg::HANG_W:0]    sil_sum;
  logic [evs_pkg::HANG_W-1:0]  sil_sat;
  logic [AW-1:0]               cap;
  logic [AW-1:0]               cnt_a;
  logic                        fits;
  logic [CAPW-1:0]             new_count;
  logic                        end_c;
  evs_pkg::evt_t               evt_c;

  evs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvr),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    hit_found = 1'b0;
    hit_idx = '0;
    claim_idx = '0;
    for (int i = 0; i < SPEAKER_SLOTS; i++) begin
      if (slot_active[i] && slot_speaker[i] == rec.spk && !hit_found) begin
        hit_found = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_active[i]) begin
        claim_idx = SLOT_W'(i);
      end
    end
  end

  assign pick = hit_found ? hit_idx : claim_idx;
  assign ch_sat = (rec.ch == '0) ? evs_pkg::CH_W'(1)
                : (rec.ch > evs_pkg::CH_W'(MAX_CHANNELS)) ? evs_pkg::CH_W'(MAX_CHANNELS)
                : rec.ch;
  assign fr_sat = ({4'b0, rec.frames} > FRW'(MAX_PACKET_FRAMES)) ? FRW'(MAX_PACKET_FRAMES)
                                                                  : {4'b0, rec.frames};
  assign ms_prod = MSP_W'(fr_sat) * MSP_W'(MS_MUL);
  assign ms_calc = evs_pkg::HANG_W'(ms_prod >> MS_SHIFT);

  assign cur_noise = slot_noise[s];
  assign cur_speak = slot_speaking[s];
  assign cur_sil = slot_silence[s];
  assign cur_count = slot_count[s];
  assign cur_ch = slot_channels[s];

  // Only bits 31:8 of the mixed sum survive, so 32-bit products suffice.
  assign mul_a = {8'b0, cur_noise} * 32'd243;
  assign mul_b = div_quo[31:0] * 32'd13;
  assign mix = mul_a + mul_b;
  assign thresh_next = evs_pkg::THR_W'(cur_noise) * evs_pkg::THR_W'(3)
                     + evs_pkg::THR_W'({cfg.threshold_offset, 8'b0});
  assign level_big = evs_pkg::PROD_W'({rec.sum, 8'b0});
  assign voiced_c = level_big > prod;
  assign sil_sum = {1'b0, cur_sil} + {1'b0, ms};
  assign sil_sat = sil_sum[evs_pkg::HANG_W] ? {evs_pkg::HANG_W{1'b1}}
                                            : sil_sum[evs_pkg::HANG_W-1:0];

  assign cap = AW'(CAP1) * AW'(cur_ch);
  assign cnt_a = AW'(cur_count) + AW'(rec.cnt);
  assign fits = cur_speak && (cnt_a <= cap);
  assign new_count = fits ? cnt_a[CAPW-1:0] : cur_count;
  assign end_c = cur_speak && ((cur_sil >= cfg.hangover_ms) ||
                               (AW'(new_count) + AW'(rec.cnt) > cap));

  always_comb begin
    if (div_quo < evs_pkg::DVD_W'(cfg.min_utterance_frames)) begin
      evt_c = evs_pkg::EV_SHORT;
    end else if (rec.qfull) begin
      evt_c = evs_pkg::EV_QFULL;
    end else if (!cfg.consumer_present) begin
      evt_c = evs_pkg::EV_NOCONS;
    end else begin
      evt_c = evs_pkg::EV_DELIVERED;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd = evs_pkg::DVD_W'(level_big);
    div_dvr = evs_pkg::DVR_W'(rec.cnt);
    unique case (state)
      S_CLAIM: begin
        div_start = 1'b1;
      end
      S_CAP: begin
        div_start = end_c;
        div_dvd = evs_pkg::DVD_W'(new_count);
        div_dvr = evs_pkg::DVR_W'(cur_ch);
      end
      default: begin
      end
    endcase
  end

  assign q_pop = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      empty <= 1'b1;
      for (int i = 0; i < SPEAKER_SLOTS; i++) begin
        slot_active[i] <= 1'b0;
      end
    end else begin
      if (pop && !empty) begin
        empty <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            rec <= q_rec;
            state <= S_CLAIM;
          end
        end
        S_CLAIM: begin
          s <= pick;
          if (!hit_found) begin
            slot_speaker[pick] <= rec.spk;
            slot_channels[pick] <= ch_sat;
            slot_count[pick] <= '0;
            slot_speaking[pick] <= 1'b0;
            slot_silence[pick] <= '0;
            slot_noise[pick] <= evs_pkg::NOISE_W'({cfg.noise_floor_init, 8'b0});
            slot_active[pick] <= 1'b1;
          end
          state <= S_LVL;
        end
        S_LVL: begin
          if (div_done) begin
            if (!cur_speak) begin
              slot_noise[s] <= mix[31:8];
            end
            state <= S_THR;
          end
        end
        S_THR: begin
          thresh <= thresh_next;
          ms <= ms_calc;
          state <= S_PROD;
        end
        S_PROD: begin
          prod <= evs_pkg::PROD_W'(rec.cnt) * evs_pkg::PROD_W'(thresh);
          state <= S_VOICE;
        end
        S_VOICE: begin
          voiced_r <= voiced_c;
          if (voiced_c) begin
            slot_speaking[s] <= 1'b1;
            slot_silence[s] <= '0;
          end else if (cur_speak) begin
            slot_silence[s] <= sil_sat;
          end
          state <= S_CAP;
        end
        S_CAP: begin
          append_r <= fits;
          slot_count[s] <= new_count;
          if (end_c) begin
            state <= S_UFR;
          end else begin
            evt_r <= evs_pkg::EV_NONE;
            ufr_r <= '0;
            uspk_r <= '0;
            uch_r <= '0;
            state <= S_OUT;
          end
        end
        S_UFR: begin
          if (div_done) begin
            evt_r <= evt_c;
            ufr_r <= div_quo[18:0];
            uspk_r <= slot_speaker[s];
            uch_r <= cur_ch;
            slot_count[s] <= '0;
            slot_speaking[s] <= 1'b0;
            slot_silence[s] <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // The result beat is loaded only once the previous one has left.
          if (empty || pop) begin
            slot_index <= 3'(s);
            voiced <= voiced_r;
            append_packet <= append_r;
            utterance_event <= evt_r;
            utterance_frames <= ufr_r;
            utterance_speaker <= uspk_r;
            utterance_channels <= uch_r;
            empty <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/energy_vad_segmenter_core.sv */
// Top level of the energy VAD segmenter: configuration registers, front
// accumulator, record queue and back end. Depends on evs_pkg, evs_front,
// evs_fifo, evs_back.
//
// Usage. Samples enter on the push/full channel, one beat per sample; the
// beat with packet_end high closes a packet. Each closed packet with a
// nonzero packet_frames yields exactly one result beat on the empty/pop
// channel; packets with zero frames are discarded. The user must write the
// registers on the cfg channel (cfg_ready is always high) only while the
// block is idle; the block itself does not enforce this. The back end takes
// a new packet record only when it has finished the last one; each record
// costs a pass of the one-bit-per-cycle divider for the level, and one more
// for the utterance frames when the packet ends an utterance.
// The front takes one sample per cycle while full is low. A queue of two
// packet records lets it keep accepting samples while the back end works;
// full rises only when both records wait.
// Reset clears all speaker slots and the accumulators, empties the result
// register and loads the register defaults. When the receiver does not
// pop, the result beat holds and the back end waits, then the queue fills.
module energy_vad_segmenter_core #(
  parameter int SPEAKER_SLOTS = 8,
  parameter int MAX_SECONDS = 10,
  parameter int SAMPLE_RATE = 48000,
  parameter int MAX_PACKET_FRAMES = 4096,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [evs_pkg::SPK_W-1:0]         speaker_id,
  input  logic [evs_pkg::CH_W-1:0]          channel_count,
  input  logic [evs_pkg::FR_W-1:0]          packet_frames,
  input  logic signed [15:0]                sample,
  input  logic                              packet_end,
  input  logic                              queue_full,
  output logic                              empty,
  input  logic                              pop,
  output logic [2:0]                        slot_index,
  output logic                              voiced,
  output logic                              append_packet,
  output logic [2:0]                        utterance_event,
  output logic [18:0]                       utterance_frames,
  output logic [evs_pkg::SPK_W-1:0]         utterance_speaker,
  output logic [evs_pkg::CH_W-1:0]          utterance_channels,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [evs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [evs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  evs_pkg::cfg_t cfg;
  evs_pkg::pkt_t f_rec;
  evs_pkg::pkt_t q_rec;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.consumer_present <= 1'b0;
      cfg.hangover_ms <= 16'd800;
      cfg.min_utterance_frames <= 19'd16800;
      cfg.noise_floor_init <= 15'd200;
      cfg.threshold_offset <= 15'd300;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        evs_pkg::CFG_CONSUMER:   cfg.consumer_present <= cfg_data[0];
        evs_pkg::CFG_HANGOVER:   cfg.hangover_ms <= cfg_data[15:0];
        evs_pkg::CFG_MIN_FRAMES: cfg.min_utterance_frames <= cfg_data;
        evs_pkg::CFG_NOISE_INIT: cfg.noise_floor_init <= cfg_data[14:0];
        evs_pkg::CFG_OFFSET:     cfg.threshold_offset <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  evs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .speaker_id    (speaker_id),
    .channel_count (channel_count),
    .packet_frames (packet_frames),
    .sample        (sample),
    .packet_end    (packet_end),
    .queue_full    (queue_full),
    .q_push        (f_push),
    .q_rec         (f_rec),
    .q_full        (q_full)
  );

  evs_fifo #(
    .DEPTH (evs_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_rec),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_rec),
    .empty (q_empty)
  );

  evs_back #(
    .SPEAKER_SLOTS     (SPEAKER_SLOTS),
    .MAX_SECONDS       (MAX_SECONDS),
    .SAMPLE_RATE       (SAMPLE_RATE),
    .MAX_PACKET_FRAMES (MAX_PACKET_FRAMES),
    .MAX_CHANNELS      (MAX_CHANNELS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_rec              (q_rec),
    .q_pop              (q_pop),
    .empty              (empty),
    .pop                (pop),
    .slot_index         (slot_index),
    .voiced             (voiced),
    .append_packet      (append_packet),
    .utterance_event    (utterance_event),
    .utterance_frames   (utterance_frames),
    .utterance_speaker  (utterance_speaker),
    .utterance_channels (utterance_channels)
  );

endmodule

/* hdl/evs_checker.sv */
// Port-level checks of the segmenter's result channel, bound to the top.
// Depends on evs_pkg and energy_vad_segmenter_core_defines.svh.
`include "energy_vad_segmenter_core_defines.svh"

module evs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          empty,
  input logic                          pop,
  input logic [2:0]                    slot_index,
  input logic [2:0]                    utterance_event,
  input logic [18:0]                   utterance_frames,
  input logic [evs_pkg::SPK_W-1:0]     utterance_speaker,
  input logic [evs_pkg::CH_W-1:0]      utterance_channels
);

  `EVS_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), empty, "result after reset")

  `EVS_ASSERT_NOW(a_no_event_zero_fields, clk, rst,
    !empty && utterance_event == evs_pkg::EV_NONE,
    utterance_frames == '0 && utterance_speaker == '0 && utterance_channels == '0,
    "fields set without an utterance end")

  `EVS_ASSERT_NOW(a_event_has_channels, clk, rst,
    !empty && utterance_event != evs_pkg::EV_NONE,
    utterance_channels != '0, "ended utterance without channels")

  `EVS_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop,
    !empty && $stable(slot_index) && $stable(utterance_speaker),
    "waiting result beat changed")

endmodule

bind energy_vad_segmenter_core evs_checker u_evs_checker (
  .clk                (clk),
  .rst                (rst),
  .empty              (empty),
  .pop                (pop),
  .slot_index         (slot_index),
  .utterance_event    (utterance_event),
  .utterance_frames   (utterance_frames),
  .utterance_speaker  (utterance_speaker),
  .utterance_channels (utterance_channels)
);
